// ===== rtl/core/oil_pkg.sv =====
// Shared types and constants for the ordered ID list.
// Used by oil_cell and ordered_id_list; depends on nothing else.
package oil_pkg;

    localparam int CAPACITY = 16;
    localparam int ID_W     = 32;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 5;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_DUMP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // What every cell does in the current cycle.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_APPEND,
        OP_INSERT,
        OP_DELETE,
        OP_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [ID_W-1:0]   id;
    } t_cell_ctrl;

endpackage

// ===== rtl/core/oil_cell.sv =====
// One slot of the ordered ID list: holds an entry and trades it with its neighbors.
// Depends on oil_pkg.
module oil_cell (
    input  logic                       i_clk,
    input  oil_pkg::t_cell_ctrl        i_ctrl,
    input  logic                       i_occupied,
    input  logic                       i_is_tail,
    input  logic [oil_pkg::ID_W-1:0]   i_left_entry,
    input  logic [oil_pkg::ID_W-1:0]   i_right_entry,
    input  logic [oil_pkg::ID_W-1:0]   i_head_entry,
    input  logic                       i_hit,
    output logic                       o_hit,
    output logic [oil_pkg::ID_W-1:0]   o_entry
);
    import oil_pkg::*;

    logic [ID_W-1:0] r_entry;
    logic [ID_W-1:0] n_entry;
    logic            w_cond;

    // Target slot: first cell along the chain whose condition holds.
    always_comb begin
        unique case (i_ctrl.op)
            OP_APPEND: w_cond = !i_occupied;
            OP_INSERT: w_cond = !i_occupied ||
                                !($signed(r_entry) < $signed(i_ctrl.id));
            OP_DELETE: w_cond = i_occupied && (r_entry == i_ctrl.id);
            default:   w_cond = 1'b0;
        endcase
    end

    assign o_hit = i_hit | w_cond;

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctrl.op)
            OP_APPEND, OP_INSERT: begin
                // Shift right behind the target, drop the new ID into it.
                if (i_hit) begin
                    n_entry = i_left_entry;
                end else if (w_cond) begin
                    n_entry = i_ctrl.id;
                end
            end
            OP_DELETE: begin
                if (o_hit) begin
                    n_entry = i_right_entry;
                end
            end
            OP_ROTATE: begin
                // Wrap the head around to the tail so the list comes back intact.
                n_entry = i_is_tail ? i_head_entry : i_right_entry;
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/core/ordered_id_list.sv =====
// Top level of the ordered ID list: a chain of oil_cell slots plus the command sequencer.
// Depends on oil_pkg and oil_cell.
//
// Bounded list of CAPACITY signed 32-bit IDs held in a row of cells, head in cell 0.
// Append, ordered insert and delete each complete in the cycle they are accepted: every
// cell tests its slot (insert and delete compare its entry with the ID), a one-bit flag
// ripples down the row to find the first matching slot, and the cells behind it shift
// one place. Each gives one status transaction; back-to-back commands are taken one per
// cycle while the output is not stalled. A dump rotates the row one place per cycle while
// the output is free and streams the head, so it gives one transaction per held entry
// (one empty-status transaction for an empty list) and stalls the input until its last
// entry is streamed; no new command is taken until the dump finishes. Results sit in an
// output register; a command is taken while that register is empty or being drained.
// Entries hold no reset value; only held slots are ever reported.
module ordered_id_list (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_cmd,
    input  logic signed [31:0]              i_id_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [31:0]              o_entry_value,
    output logic [1:0]                      o_status,
    output logic [4:0]                      o_entry_count,
    output logic                            o_last_result
);
    import oil_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state              r_state;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  r_idx;
    logic                r_out_valid;
    logic [ID_W-1:0]     r_out_value;
    t_status             r_out_status;
    logic                r_out_last;

    logic                w_out_free;
    logic                w_accept;
    logic                w_dump_step;
    logic                w_full;
    t_cmd                w_cmd;
    t_cell_ctrl          w_ctrl;

    logic [ID_W-1:0]     w_entry [CAPACITY];
    logic [CAPACITY:0]   w_hit;

    assign w_cmd       = t_cmd'(i_cmd);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !w_out_free;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_dump_step = (r_state == S_DUMP) && w_out_free;
    assign w_full      = (r_count >= COUNT_W'(CAPACITY));

    always_comb begin
        w_ctrl.id = i_id_value;
        w_ctrl.op = OP_HOLD;
        if (w_dump_step) begin
            w_ctrl.op = OP_ROTATE;
        end else if (w_accept) begin
            unique case (w_cmd)
                CMD_APPEND: w_ctrl.op = w_full ? OP_HOLD : OP_APPEND;
                CMD_INSERT: w_ctrl.op = w_full ? OP_HOLD : OP_INSERT;
                CMD_DELETE: w_ctrl.op = OP_DELETE;
                default:    w_ctrl.op = OP_HOLD;
            endcase
        end
    end

    assign w_hit[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [ID_W-1:0] w_left;
            logic [ID_W-1:0] w_right;
            if (g == 0) begin : g_head
                assign w_left = '0;
            end else begin : g_mid
                assign w_left = w_entry[g-1];
            end
            if (g == CAPACITY - 1) begin : g_end
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_entry[g+1];
            end
            oil_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_occupied    (COUNT_W'(g) < r_count),
                .i_is_tail     ((COUNT_W'(g) + COUNT_W'(1)) == r_count),
                .i_left_entry  (w_left),
                .i_right_entry (w_right),
                .i_head_entry  (w_entry[0]),
                .i_hit         (w_hit[g]),
                .o_hit         (w_hit[g+1]),
                .o_entry       (w_entry[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_out_last <= 1'b1;
                        unique case (w_cmd)
                            CMD_APPEND, CMD_INSERT: begin
                                r_out_valid <= 1'b1;
                                r_out_value <= i_id_value;
                                if (w_full) begin
                                    r_out_status <= ST_FULL;
                                end else begin
                                    r_out_status <= ST_DONE;
                                    r_count      <= r_count + COUNT_W'(1);
                                end
                            end
                            CMD_DELETE: begin
                                r_out_valid <= 1'b1;
                                r_out_value <= i_id_value;
                                if (w_hit[CAPACITY]) begin
                                    r_out_status <= ST_DONE;
                                    r_count      <= r_count - COUNT_W'(1);
                                end else begin
                                    r_out_status <= ST_NOTFOUND;
                                end
                            end
                            default: begin
                                if (r_count == '0) begin
                                    r_out_valid  <= 1'b1;
                                    r_out_value  <= '0;
                                    r_out_status <= ST_EMPTY;
                                end else begin
                                    // Hold the output empty; the dump state streams entries.
                                    r_out_valid <= 1'b0;
                                    r_idx       <= '0;
                                    r_state     <= S_DUMP;
                                end
                            end
                        endcase
                    end else if (w_out_free) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_DUMP: begin
                    if (w_dump_step) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= w_entry[0];
                        r_out_status <= ST_DONE;
                        r_out_last   <= (r_idx + COUNT_W'(1)) == r_count;
                        r_idx        <= r_idx + COUNT_W'(1);
                        if ((r_idx + COUNT_W'(1)) == r_count) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_value = $signed(r_out_value);
    assign o_status      = r_out_status;
    assign o_entry_count = OUT_CNT_W'(r_count);
    assign o_last_result = r_out_last;

endmodule
